[rtl/float_to_int8_quantizer_unit_macros.svh]
// ---------------------------------------------------------------------------
// float_to_int8_quantizer_unit_macros.svh
// Assertion macros used by the quantizer checker.
// ---------------------------------------------------------------------------
`ifndef FLOAT_TO_INT8_QUANTIZER_UNIT_MACROS_SVH
`define FLOAT_TO_INT8_QUANTIZER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define FQ8_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define FQ8_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/fq8_pkg.sv]
// ---------------------------------------------------------------------------
// fq8_pkg
// Types, constants and helpers of the float to int8 quantizer.
// ---------------------------------------------------------------------------
`default_nettype none

package fq8_pkg;

  localparam int SIG_W      = 24;  // significand with hidden bit
  localparam int EXP_W      = 8;
  localparam int LZ_W       = 5;
  localparam int QDIV_W     = 11;  // quotient bits of na * 2^10 / nb
  localparam int K_W        = 11;  // signed exponent difference
  localparam int SH_W       = 4;
  localparam int X_W        = 10;  // floor(2 * |sample / scale|)
  localparam int W_W        = 12;  // twice the offset value, signed
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int STAGES     = 6;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO  = 2'd1;

  localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;
  localparam logic [EXP_W-1:0] EXP_ONES = 8'hFF;
  localparam logic signed [K_W-1:0] K_SAT = 11'sd10;
  localparam logic signed [7:0] Q_MAX = 8'sd127;
  localparam logic signed [7:0] Q_MIN = -8'sd128;

  // forced result classes decided ahead of the arithmetic
  typedef enum logic [1:0] {
    FRC_NONE,
    FRC_ZERO,
    FRC_POS,
    FRC_NEG
  } force_t;

  typedef struct packed {
    logic [31:0] sample_word;
    logic        end_mark;
  } fq8_in_t;

  typedef struct packed {
    logic signed [7:0] quantized;
    logic              end_flag;
  } fq8_out_t;

  // leading zeros of a 24-bit significand (zero input gives 0)
  function automatic logic [LZ_W-1:0] lzc24(input logic [SIG_W-1:0] m);
    logic [LZ_W-1:0] n;
    n = '0;
    for (int i = 0; i < SIG_W; i++) begin
      if (m[i]) begin
        n = LZ_W'(SIG_W - 1 - i);
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

[rtl/fq8_stream_if.sv]
// ---------------------------------------------------------------------------
// fq8_stream_if
// Valid/ready stream channel with a typed payload.
// ---------------------------------------------------------------------------
`default_nettype none

interface fq8_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/float_to_int8_quantizer_unit.sv]
// ---------------------------------------------------------------------------
// float_to_int8_quantizer_unit
// Affine int8 quantizer: round(sample / scale + zero_offset), saturated.
// ---------------------------------------------------------------------------
//  channel   | dir  | payload                          | transaction
//  ----------+------+----------------------------------+-----------------------
//  samples   | in   | sample_word[31:0], end_mark      | valid & ready
//  results   | out  | quantized[7:0] signed, end_flag  | valid & ready
//  cfg       | in   | cfg_index, cfg_data[31:0]        | cfg_we (write only)
//
//  Six register stages: decode, normalize, three divider stages of a
//  restoring divider (11 quotient bits), and the round/saturate output register.
//  One transaction per cycle sustained while results.ready stays high.
//  Each stage advances when it is empty or the next one advances, so a
//  stalled output never loses or repeats a transaction and bubbles still fill.
//  rst (synchronous) clears valid bits and the zero offset, and sets the scale to 1.0.
// ---------------------------------------------------------------------------
`default_nettype none

module float_to_int8_quantizer_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fq8_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fq8_pkg::CFG_DATA_W-1:0]  cfg_data,
  fq8_stream_if.sink                      samples,
  fq8_stream_if.source                    results
);
  import fq8_pkg::*;

  // one restoring step: doubled remainder against the divisor
  function automatic logic [SIG_W:0] div_step(input logic [SIG_W-1:0] r,
                                              input logic [SIG_W-1:0] d);
    logic [SIG_W:0] t;
    logic [SIG_W:0] s;
    t = {r, 1'b0};
    s = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      return {1'b1, s[SIG_W-1:0]};
    end
    return {1'b0, t[SIG_W-1:0]};
  endfunction

  // ---------------- configuration registers ----------------
  logic [31:0]       scale_word;
  logic signed [7:0] zero_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_word  <= SCALE_RESET;
      zero_offset <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCALE: scale_word  <= cfg_data[31:0];
        REG_ZERO:  zero_offset <= signed'(cfg_data[7:0]);
        default:   ;
      endcase
    end
  end

  // ---------------- stage enables ----------------
  // stage i loads when empty or when stage i+1 loads
  logic v1, v2, v3, v4, v5, v6;
  logic en1, en2, en3, en4, en5, en6;

  assign en6 = !v6 || results.ready;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign samples.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (en1) v1 <= samples.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
    end
  end

  // ---------------- stage 1: unpack, special cases ----------------
  logic [EXP_W-1:0] s_exp, c_exp;
  logic             scale_bad;
  force_t           frc1_next;

  assign s_exp = samples.payload.sample_word[30:23];
  assign c_exp = scale_word[30:23];
  // scale must be a positive finite nonzero value
  assign scale_bad = scale_word[31] || (scale_word[30:0] == '0) || (c_exp == EXP_ONES);

  always_comb begin
    frc1_next = FRC_NONE;
    if (scale_bad) begin
      frc1_next = FRC_ZERO;
    end else if (s_exp == EXP_ONES) begin
      if (samples.payload.sample_word[22:0] != '0) begin
        frc1_next = FRC_ZERO;  // NaN
      end else begin
        frc1_next = samples.payload.sample_word[31] ? FRC_NEG : FRC_POS;
      end
    end
  end

  logic [SIG_W-1:0] ma1, mb1;
  logic [EXP_W-1:0] ea1, eb1;
  logic             sign1, end1;
  force_t           frc1;

  always_ff @(posedge clk) begin
    if (en1) begin
      ma1   <= {s_exp != '0, samples.payload.sample_word[22:0]};
      ea1   <= (s_exp == '0) ? EXP_W'(1) : s_exp;
      mb1   <= {c_exp != '0, scale_word[22:0]};
      eb1   <= (c_exp == '0) ? EXP_W'(1) : c_exp;
      sign1 <= samples.payload.sample_word[31];
      end1  <= samples.payload.end_mark;
      frc1  <= frc1_next;
    end
  end

  // ---------------- stage 2: normalize, exponent classing ----------------
  // 2|x| = (na/nb) * 2^k with na, nb in [2^23, 2^24)
  logic [LZ_W-1:0]        lza, lzb;
  logic signed [K_W-1:0]  k;
  logic                   nz1;
  force_t                 frc2_next;

  assign lza = lzc24(ma1);
  assign lzb = lzc24(mb1);
  assign k   = signed'(K_W'(ea1)) - signed'(K_W'(lza)) - signed'(K_W'(eb1))
             + signed'(K_W'(lzb)) + signed'(K_W'(1));
  assign nz1 = (ma1 != '0);

  always_comb begin
    frc2_next = frc1;
    // |x| >= 256 always saturates whatever the zero point
    if (frc1 == FRC_NONE && nz1 && k >= K_SAT) begin
      frc2_next = sign1 ? FRC_NEG : FRC_POS;
    end
  end

  logic [SIG_W-1:0] na2, nb2;
  logic [SH_W-1:0]  sh2;
  logic             tiny2, nz2, sign2, end2;
  force_t           frc2;

  always_ff @(posedge clk) begin
    if (en2) begin
      na2   <= ma1 << lza;
      nb2   <= mb1 << lzb;
      sh2   <= SH_W'(K_SAT - k);
      tiny2 <= !nz1 || (k < signed'(K_W'(0)));  // floor(2|x|) is 0
      nz2   <= nz1;
      sign2 <= sign1;
      end2  <= end1;
      frc2  <= frc2_next;
    end
  end

  // ---------------- stages 3-5: restoring divider ----------------
  logic [SIG_W-1:0] r3_0, r3_1, r3_2, r3_3;
  logic [SIG_W:0]   d3_1, d3_2, d3_3;
  logic             b10;

  assign b10  = (na2 >= nb2);
  assign r3_0 = b10 ? (na2 - nb2) : na2;
  assign d3_1 = div_step(r3_0, nb2);
  assign r3_1 = d3_1[SIG_W-1:0];
  assign d3_2 = div_step(r3_1, nb2);
  assign r3_2 = d3_2[SIG_W-1:0];
  assign d3_3 = div_step(r3_2, nb2);
  assign r3_3 = d3_3[SIG_W-1:0];

  logic [SIG_W-1:0] rem3, nb3;
  logic [3:0]       q3;
  logic [SH_W-1:0]  sh3;
  logic             tiny3, nz3, sign3, end3;
  force_t           frc3;

  always_ff @(posedge clk) begin
    if (en3) begin
      rem3  <= r3_3;
      nb3   <= nb2;
      q3    <= {b10, d3_1[SIG_W], d3_2[SIG_W], d3_3[SIG_W]};
      sh3   <= sh2;
      tiny3 <= tiny2;
      nz3   <= nz2;
      sign3 <= sign2;
      end3  <= end2;
      frc3  <= frc2;
    end
  end

  logic [SIG_W:0] d4_0, d4_1, d4_2, d4_3;

  assign d4_0 = div_step(rem3, nb3);
  assign d4_1 = div_step(d4_0[SIG_W-1:0], nb3);
  assign d4_2 = div_step(d4_1[SIG_W-1:0], nb3);
  assign d4_3 = div_step(d4_2[SIG_W-1:0], nb3);

  logic [SIG_W-1:0] rem4, nb4;
  logic [7:0]       q4;
  logic [SH_W-1:0]  sh4;
  logic             tiny4, nz4, sign4, end4;
  force_t           frc4;

  always_ff @(posedge clk) begin
    if (en4) begin
      rem4  <= d4_3[SIG_W-1:0];
      nb4   <= nb3;
      q4    <= {q3, d4_0[SIG_W], d4_1[SIG_W], d4_2[SIG_W], d4_3[SIG_W]};
      sh4   <= sh3;
      tiny4 <= tiny3;
      nz4   <= nz3;
      sign4 <= sign3;
      end4  <= end3;
      frc4  <= frc3;
    end
  end

  logic [SIG_W:0] d5_0, d5_1, d5_2;

  assign d5_0 = div_step(rem4, nb4);
  assign d5_1 = div_step(d5_0[SIG_W-1:0], nb4);
  assign d5_2 = div_step(d5_1[SIG_W-1:0], nb4);

  logic [QDIV_W-1:0] q5;
  logic              remnz5;
  logic [SH_W-1:0]   sh5;
  logic              tiny5, nz5, sign5, end5;
  force_t            frc5;

  always_ff @(posedge clk) begin
    if (en5) begin
      q5     <= {q4, d5_0[SIG_W], d5_1[SIG_W], d5_2[SIG_W]};
      remnz5 <= (d5_2[SIG_W-1:0] != '0);
      sh5    <= sh4;
      tiny5  <= tiny4;
      nz5    <= nz4;
      sign5  <= sign4;
      end5   <= end4;
      frc5   <= frc4;
    end
  end

  // ---------------- stage 6: align, add zero point, round, clamp ----------------
  // 2y = W + g with 0 <= g < 1, g nonzero exactly when sticky
  logic [X_W-1:0]        xmag;
  logic [QDIV_W-1:0]     mask;
  logic                  sticky;
  logic signed [W_W-1:0] xs, zp2, w, wr;
  logic signed [W_W-1:0] qw;
  logic signed [7:0]     q_next;

  always_comb begin
    mask   = (QDIV_W'(1) << sh5) - QDIV_W'(1);
    xmag   = tiny5 ? '0 : X_W'(q5 >> sh5);
    sticky = tiny5 ? nz5 : (remnz5 || ((q5 & mask) != '0));
    xs     = signed'(W_W'(xmag));
    zp2    = W_W'(zero_offset) <<< 1;
    if (!sign5) begin
      w = xs + zp2;
    end else if (sticky) begin
      w = zp2 - xs - signed'(W_W'(1));
    end else begin
      w = zp2 - xs;
    end
    // half away from zero; an exact negative value rounds via W / 2
    wr = (w[W_W-1] && !sticky) ? w : (w + signed'(W_W'(1)));
    qw = wr >>> 1;
    if (qw > signed'(W_W'(Q_MAX))) begin
      q_next = Q_MAX;
    end else if (qw < W_W'(Q_MIN)) begin
      q_next = Q_MIN;
    end else begin
      q_next = qw[7:0];
    end
    case (frc5)
      FRC_NONE: ;
      FRC_ZERO: q_next = '0;
      FRC_POS:  q_next = Q_MAX;
      FRC_NEG:  q_next = Q_MIN;
      default:  q_next = '0;
    endcase
  end

  fq8_out_t out6;

  always_ff @(posedge clk) begin
    if (en6) begin
      out6.quantized <= q_next;
      out6.end_flag  <= end5;
    end
  end

  assign results.valid   = v6;
  assign results.payload = out6;

endmodule

`default_nettype wire

[rtl/fq8_checker.sv]
// ---------------------------------------------------------------------------
// fq8_checker
// Port-level checks of the quantizer, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "float_to_int8_quantizer_unit_macros.svh"

module fq8_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input fq8_pkg::fq8_out_t out_payload
);
  import fq8_pkg::*;

  // transactions in flight between the two channels
  logic [3:0] occ;
  logic [3:0] occ_next;

  always_comb begin
    occ_next = occ;
    if (in_valid && in_ready) occ_next = occ_next + 4'd1;
    if (out_valid && out_ready) occ_next = occ_next - 4'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ_next;
    end
  end

  `FQ8_ASSERT_SAME(a_occ_bound, 1'b1, occ <= 4'(STAGES), "more in flight than stages")
  `FQ8_ASSERT_SAME(a_no_invent, out_valid, occ != '0, "result with nothing in flight")
  `FQ8_ASSERT_SAME(a_reset_empty, $past(rst), !out_valid, "result valid right after reset")
  `FQ8_ASSERT_SAME(a_open_input, !out_valid, in_ready, "input blocked with output empty")
  `FQ8_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_payload), "stalled result changed")

endmodule

bind float_to_int8_quantizer_unit fq8_checker u_fq8_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (samples.valid),
  .in_ready    (samples.ready),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .out_payload (results.payload)
);

`default_nettype wire

[verif/float_to_int8_quantizer_unit_tb.sv]
// ---------------------------------------------------------------------------
// float_to_int8_quantizer_unit_tb
// Self-checking bench for the float to int8 quantizer. Streams directed and
// random single-precision samples under several scale/zero-point settings,
// with random sender bursts and receiver stalls, and compares every result
// against a real-arithmetic predictor kept in a small scoreboard class.
// ---------------------------------------------------------------------------
`default_nettype none

module float_to_int8_quantizer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fq8_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 12;   // settling margin after the last result
  localparam int ITEMS_PER_PHASE = 135;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fq8_stream_if #(.payload_t(fq8_in_t))  sample_ch ();
  fq8_stream_if #(.payload_t(fq8_out_t)) result_ch ();

  float_to_int8_quantizer_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .samples  (sample_ch),
    .results  (result_ch)
  );

  // -------------------------------------------------------------------------
  // Scoreboard: own copy of the registers, the quantizer prediction and the
  // queue of results still owed by the block.
  // -------------------------------------------------------------------------
  class quant_scoreboard;
    logic [31:0]      scale_reg;
    logic signed [7:0] zero_reg;
    fq8_out_t         owed_q[$];
    int               errors;

    function new();
      scale_reg = SCALE_RESET;
      zero_reg  = '0;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      if (idx == REG_SCALE) begin
        scale_reg = data;
      end else if (idx == REG_ZERO) begin
        zero_reg = data[7:0];
      end
    endfunction

    // exact value of a finite single-precision pattern
    function real word_value(logic [31:0] w);
      real m;
      int  e;
      e = w[30:23];
      m = real'(w[22:0]);
      if (e == 0) begin
        e = 1;
      end else begin
        m = m + 8388608.0;
      end
      m = m * (2.0 ** (e - 150));
      return w[31] ? -m : m;
    endfunction

    function logic signed [7:0] quantize(logic [31:0] w);
      real t;
      real frac;
      int  q;
      // scale must be a positive finite nonzero number
      if (scale_reg[31] || scale_reg[30:0] == '0 || scale_reg[30:23] == EXP_ONES) begin
        return 8'sd0;
      end
      if (w[30:23] == EXP_ONES) begin
        if (w[22:0] != '0) return 8'sd0;           // NaN
        return w[31] ? Q_MIN : Q_MAX;              // infinity saturates by sign
      end
      t = word_value(w) / word_value(scale_reg) + real'(zero_reg);
      if (t >= 127.0) return Q_MAX;
      if (t <= -128.0) return Q_MIN;
      q = $rtoi(t);
      frac = t - real'(q);
      if (frac >= 0.5) q = q + 1;                  // ties away from zero
      else if (frac <= -0.5) q = q - 1;
      if (q > 127) q = 127;
      if (q < -128) q = -128;
      return 8'(q);
    endfunction

    function void note_sample(fq8_in_t s);
      fq8_out_t r;
      r.quantized = quantize(s.sample_word);
      r.end_flag  = s.end_mark;
      owed_q.push_back(r);
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(fq8_out_t got);
      fq8_out_t want;
      if (owed_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result q=%0d end=%0b",
                                  got.quantized, got.end_flag));
        return;
      end
      want = owed_q.pop_front();
      if (got.quantized !== want.quantized)
        report_mismatch($sformatf("quantized got %0d want %0d",
                                  got.quantized, want.quantized));
      if (got.end_flag !== want.end_flag)
        report_mismatch($sformatf("end_flag got %0b want %0b",
                                  got.end_flag, want.end_flag));
    endtask
  endclass

  quant_scoreboard sb = new();

  // -------------------------------------------------------------------------
  // Clock, cycle limit
  // -------------------------------------------------------------------------
  initial clk = 1'b0;
  always #10 clk = ~clk;

  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Receiver: checks each result transaction, stalls on its own pattern.
  // The pattern mode is redrawn at random: no stalls, light, heavy.
  // -------------------------------------------------------------------------
  logic [1:0] stall_mode = 2'd0;
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      sb.check_result(result_ch.payload);
    end
    if (cycle_count % 256 == 0) begin
      stall_mode <= 2'($urandom_range(0, 2));
    end
    case (stall_mode)
      2'd0: begin
        result_ch.ready <= 1'b1;
      end
      2'd1: begin
        result_ch.ready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        result_ch.ready <= ($urandom_range(0, 3) == 0);
      end
    endcase
  end

  // -------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps between them
  // -------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_sample(logic [31:0] w, logic mark);
    fq8_in_t s;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        sample_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s.sample_word = w;
    s.end_mark    = mark;
    sample_ch.valid   <= 1'b1;
    sample_ch.payload <= s;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    sb.note_sample(s);
  endtask

  // wait until every owed result has come, then let the pipe settle
  task automatic drain();
    sample_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // drives a register write on the config port, then returns it to idle
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // random sample mostly near the scale so results land inside the int8 range
  function automatic logic [31:0] rand_sample(logic [31:0] scale);
    logic [31:0] w;
    int e;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        e = int'(scale[30:23]) + $urandom_range(0, 9) - 3;
        if (e < 1) e = 1;
        if (e > 254) e = 254;
        w = {1'($urandom), 8'(e), 23'($urandom)};
        if ($urandom_range(0, 2) == 0) w[15:0] = '0;   // favors exact ties
      end
      6, 7: begin
        w = $urandom;
      end
      8: begin
        case ($urandom_range(0, 3))
          0: w = {1'($urandom), 8'hFF, 23'd0};               // infinity
          1: w = {1'($urandom), 8'hFF, 23'($urandom) | 23'd1}; // NaN
          2: w = {1'($urandom), 31'd0};                      // zero
          default: w = {1'($urandom), 8'd0, 23'($urandom)};  // subnormal
        endcase
      end
      default: begin
        w = {1'($urandom), 8'($urandom_range(0, 40)), 23'($urandom)};
      end
    endcase
    return w;
  endfunction

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      send_sample(rand_sample(sb.scale_reg), 1'($urandom));
    end
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    logic [31:0] scales[$];
    logic [7:0]  zeros[$];

    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    sample_ch.valid = 1'b0;
    sample_ch.payload = '0;
    result_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at reset settings: scale 1.0, zero point 0
    send_sample(32'h0000_0000, 1'b0);   // +0
    send_sample(32'h8000_0000, 1'b1);   // -0
    send_sample(32'h3F00_0000, 1'b0);   // 0.5 tie -> 1
    send_sample(32'hBF00_0000, 1'b0);   // -0.5 tie -> -1
    send_sample(32'h4020_0000, 1'b0);   // 2.5 tie -> 3
    send_sample(32'hC020_0000, 1'b1);   // -2.5 tie -> -3
    send_sample(32'h3EFF_FFFF, 1'b0);   // just under half -> 0
    send_sample(32'h42FE_0000, 1'b0);   // 127 saturates
    send_sample(32'h42FD_0000, 1'b0);   // 126.5 tie -> 127
    send_sample(32'hC300_0000, 1'b0);   // -128
    send_sample(32'hC2FF_0000, 1'b0);   // -127.5 tie -> -128
    send_sample(32'h7F80_0000, 1'b1);   // +inf
    send_sample(32'hFF80_0000, 1'b0);   // -inf
    send_sample(32'h7FC0_0000, 1'b0);   // quiet NaN
    send_sample(32'hFFFF_FFFF, 1'b0);   // NaN, all ones
    send_sample(32'h7F7F_FFFF, 1'b0);   // largest finite
    send_sample(32'hFF7F_FFFF, 1'b1);   // most negative finite
    send_sample(32'h0000_0001, 1'b0);   // smallest subnormal
    send_sample(32'h807F_FFFF, 1'b0);   // largest negative subnormal
    run_random(ITEMS_PER_PHASE);

    // hold off until the block has delivered everything
    drain();

    // scale / zero-point settings, extremes and invalid scales included
    scales = '{32'h3F00_0000, 32'h4100_0000, 32'h0000_0001, 32'h7F7F_FFFF,
               32'h0000_0000, 32'h8000_0000, 32'hBF80_0000, 32'h7F80_0000,
               32'h7FC0_0001, 32'h3DCC_CCCD, 32'h3C23_D70A};
    zeros  = '{8'h80, 8'h7F, 8'h00, 8'hFF, 8'h05, 8'h80, 8'h7F, 8'h00,
               8'h11, 8'hF6, 8'h80};
    for (int p = 0; p < scales.size(); p++) begin
      write_cfg(REG_SCALE, scales[p]);
      write_cfg(REG_ZERO, {24'($urandom), zeros[p]});  // upper bits unused
      if (p == 3) begin
        write_cfg(2'd3, $urandom);   // unmapped index, must be ignored
      end
      run_random(ITEMS_PER_PHASE - 15 * (p % 3));
      drain();
    end

    // a couple of random positive finite scales
    for (int p = 0; p < 2; p++) begin
      write_cfg(REG_SCALE, {1'b0, 8'($urandom_range(100, 150)), 23'($urandom)});
      write_cfg(REG_ZERO, 32'($urandom));
      run_random(ITEMS_PER_PHASE);
      drain();
    end

    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/fq8_pkg.sv
rtl/fq8_stream_if.sv
rtl/float_to_int8_quantizer_unit.sv
rtl/fq8_checker.sv
verif/float_to_int8_quantizer_unit_tb.sv
